// ===== design/jlfd_pkg.sv =====
// Shared types and marker constants for the lossless JPEG frame detector.
package jlfd_pkg;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_SOF3   = 8'hC3;
  localparam logic [7:0] MK_SOF7   = 8'hC7;
  localparam logic [7:0] MK_SOF11  = 8'hCB;
  localparam logic [7:0] MK_SOF15  = 8'hCF;

  localparam logic [2:0] MIN_BYTES = 3'd4;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_MARKER = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    WHY_LOSSLESS   = 3'd0,
    WHY_SOS        = 3'd1,
    WHY_EOI        = 3'd2,
    WHY_NOT_MARKER = 3'd3,
    WHY_BAD_LENGTH = 3'd4,
    WHY_ENDED      = 3'd5,
    WHY_SHORT      = 3'd6
  } reason_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] skip;
    logic [7:0]  len_hi;
    logic        decided;
    reason_t     reason;
    logic [2:0]  bytes_seen;
  } walk_state_t;

  typedef struct packed {
    logic    lossless;
    reason_t reason;
  } verdict_t;

  localparam walk_state_t WALK_RESET = '{
    phase:      PH_PREFIX,
    skip:       16'd0,
    len_hi:     8'd0,
    decided:    1'b0,
    reason:     WHY_LOSSLESS,
    bytes_seen: 3'd0
  };

endpackage

// ===== design/jpeg_lossless_frame_detector.sv =====
// Top level: input register, marker walker and verdict register of the frame detector.
// Order: a last byte is loaded into the input register, and its verdict, formed by the
//   combinational walker, then into the result register; a stalled output can hold it back.
// Throughput: one byte per cycle; only a last byte waits on a stalled verdict register.
// Reset (rst, synchronous, active high) clears both valid flags and puts the walker in
//   its prefix phase with no decision held; no clearing pass is needed.
module jpeg_lossless_frame_detector (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_lossless,
  output logic [2:0] stop_reason
);
  import jlfd_pkg::*;

  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       advance;
  logic       accept;
  verdict_t   verdict;

  // bytes without a verdict never wait on the output side
  assign advance  = q_valid && (!q_last || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= data_byte;
      q_last <= last_byte;
    end
  end

  jlfd_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (q_byte),
    .last_in (q_last),
    .verdict (verdict)
  );

  jlfd_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && q_last),
    .verdict     (verdict),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .is_lossless (is_lossless),
    .stop_reason (stop_reason)
  );

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && q_last && out_valid && out_stall)
    else $error("input stalled without a blocked verdict");
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    advance && q_last |=> out_valid) else $error("last byte produced no verdict");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(advance && q_last))
    else $error("verdict without a last byte");
`endif

endmodule

// ===== design/jlfd_walker.sv =====
// Marker segment walker: parse state registers and per-byte next-state logic.
module jlfd_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output jlfd_pkg::verdict_t verdict
);
  import jlfd_pkg::*;

  walk_state_t st;
  walk_state_t st_next;
  walk_state_t w;
  logic [15:0] len;
  logic [15:0] skip_dec;

  always_comb begin
    w = st;
    w.bytes_seen = (st.bytes_seen < MIN_BYTES) ? st.bytes_seen + 3'd1 : st.bytes_seen;
    len = {st.len_hi, byte_in};
    skip_dec = st.skip - 16'd1;
    if (!st.decided) begin
      case (st.phase)
        PH_MARKER: begin
          if (byte_in == MK_PREFIX) begin
            w.phase = PH_MARKER;
          end else if (byte_in == MK_EOI) begin
            w.decided = 1'b1;
            w.reason = WHY_EOI;
          end else if (byte_in inside {MK_TEM, MK_SOI, [MK_RST0:MK_RST7]}) begin
            w.phase = PH_PREFIX;
          end else if (byte_in == MK_SOS) begin
            w.decided = 1'b1;
            w.reason = WHY_SOS;
          end else if (byte_in inside {MK_SOF3, MK_SOF7, MK_SOF11, MK_SOF15}) begin
            w.decided = 1'b1;
            w.reason = WHY_LOSSLESS;
          end else begin
            w.phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          w.len_hi = byte_in;
          w.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len < 16'd2) begin
            w.decided = 1'b1;
            w.reason = WHY_BAD_LENGTH;
          end else begin
            w.skip = len - 16'd2;
            w.phase = (len != 16'd2) ? PH_SKIP : PH_PREFIX;
          end
        end
        PH_SKIP: begin
          w.skip = skip_dec;
          if (skip_dec == 16'd0) w.phase = PH_PREFIX;
        end
        default: begin
          // prefix slot; the final byte here is never examined
          if (!last_in) begin
            if (byte_in != MK_PREFIX) begin
              w.decided = 1'b1;
              w.reason = WHY_NOT_MARKER;
            end else begin
              w.phase = PH_MARKER;
            end
          end
        end
      endcase
    end

    if (w.bytes_seen < MIN_BYTES) verdict.reason = WHY_SHORT;
    else if (w.decided)           verdict.reason = w.reason;
    else                          verdict.reason = WHY_ENDED;
    verdict.lossless = (verdict.reason == WHY_LOSSLESS);

    st_next = last_in ? WALK_RESET : w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= WALK_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    st.phase <= PH_SKIP) else $error("walker phase out of range");
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_SKIP |-> st.skip != 16'd0) else $error("skip phase with zero count");
  a_reason_idle: assert property (@(posedge clk) disable iff (rst)
    !st.decided |-> st.reason == WHY_LOSSLESS) else $error("reason set while undecided");
  a_decided_holds: assert property (@(posedge clk) disable iff (rst)
    st.decided && step && !last_in |=> st.decided && $stable(st.reason))
    else $error("decision lost before last byte");
`endif

endmodule

// ===== design/jlfd_out_reg.sv =====
// Result register holding one verdict until the downstream transfer.
module jlfd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  jlfd_pkg::verdict_t verdict,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               is_lossless,
  output logic [2:0]         stop_reason
);
  import jlfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_lossless <= verdict.lossless;
      stop_reason <= verdict.reason;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !out_valid || !out_stall) else $error("verdict overwritten while stalled");
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_lossless == (stop_reason == WHY_LOSSLESS))
    else $error("lossless flag disagrees with reason");
  a_reason_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stop_reason <= WHY_SHORT) else $error("stop reason out of range");
`endif

endmodule
